// ----- rtl/mred_pkg.sv -----
// Package for the mouse report event decoder.
// Holds event codes, field widths and the divider handshake type; depends on nothing.

package mred_pkg;

	localparam int TIME_W    = 64;
	localparam int TPM_W     = 32;
	localparam int MAXMS_W   = 16;
	localparam int MOTION_W  = 8;
	localparam int NUM_BTN   = 3;
	localparam int KIND_W    = 3;
	localparam int BTN_IDX_W = 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [MAXMS_W-1:0] MAXMS_RESET = MAXMS_W'(400);
	localparam logic [TPM_W-1:0]   TPM_RESET   = TPM_W'(1000000);

	localparam logic [KIND_W-1:0] EV_MOVE  = 3'd0;
	localparam logic [KIND_W-1:0] EV_WHEEL = 3'd1;
	localparam logic [KIND_W-1:0] EV_DOWN  = 3'd2;
	localparam logic [KIND_W-1:0] EV_UP    = 3'd3;
	localparam logic [KIND_W-1:0] EV_DBL   = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_DBLCLK_MS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_MS  = 2'd1;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// ----- rtl/mred_div.sv -----
// Restoring divider for the press interval: one quotient bit per cycle.
// Depends on mred_pkg for the operand widths and the status struct.

module mred_div
	import mred_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [TIME_W-1:0] dividend,
	input  logic [TPM_W-1:0]  divisor,
	output div_stat_t         stat,
	output logic [TIME_W-1:0] quotient
);

	localparam int CNT_W = $clog2(TIME_W);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [TIME_W-1:0] work_q;
	logic [TPM_W-1:0]  rem_q;
	logic [TPM_W-1:0]  dvs_q;
	logic [TPM_W:0]    trial;
	logic              fits;

	// The dividend shifts out at the top while quotient bits shift in at the bottom.
	assign trial = {rem_q, work_q[TIME_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(TIME_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			work_q <= dividend;
			rem_q  <= '0;
			dvs_q  <= divisor;
		end else if (busy_q) begin
			work_q <= {work_q[TIME_W-2:0], fits};
			rem_q  <= fits ? TPM_W'(trial - {1'b0, dvs_q}) : trial[TPM_W-1:0];
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = work_q;

endmodule

// ----- rtl/mouse_report_event_decoder.sv -----
// Top level of the mouse report event decoder: sequencer, button state and result register.
// Depends on mred_pkg and instantiates the interval divider mred_div.

// Each accepted report is expanded into up to five events, in the order move, wheel, then one
// event for each of the left, right and middle buttons whose bit changed since the previous
// report; the final event of a report carries tlast. A report is held while its events are
// produced one at a time, and s_axis_tready stays low until the last of them has been placed in
// the output register. A press of an armed button in a report without motion additionally runs
// the shared restoring divider, which produces one quotient bit per cycle, to find the press
// interval in milliseconds. The output register lets the next report be accepted while the
// final event of the previous one still waits on m_axis_tready. Configuration writes are always
// taken; they must only be issued while no report is in flight. A zero tick rate makes every
// interval too long, so no double click is then detected.

module mouse_report_event_decoder
	import mred_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// Configuration write channel.
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// Report stream.
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// From bit 0: time_ticks[63:0], buttons[66:64], dx[74:67], dy[82:75], dz[90:83], zero pad.
	input  logic [95:0]           s_axis_tdata,
	// Event stream.
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// From bit 0: move_x[7:0], move_y[15:8], wheel[23:16].
	output logic [23:0]           m_axis_tdata,
	// From bit 0: event_kind[2:0], which_button[4:3].
	output logic [4:0]            m_axis_tuser,
	output logic                  m_axis_tlast
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EMIT = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;

	// Pending event slots, lowest first.
	localparam int SLOT_MOVE  = 0;
	localparam int SLOT_WHEEL = 1;
	localparam int SLOT_BTN0  = 2;
	localparam int NUM_SLOT   = SLOT_BTN0 + NUM_BTN;

	// Configuration registers.
	logic [MAXMS_W-1:0] max_ms_q;
	logic [TPM_W-1:0]   tpm_q;

	// Persistent button state.
	logic [NUM_BTN-1:0] prev_btn_q;
	logic [NUM_BTN-1:0] armed_q;
	logic [TIME_W-1:0]  press_time_q [NUM_BTN];

	// The report being worked on.
	logic [1:0]          state_q;
	logic [NUM_SLOT-1:0] pend_q;
	logic [TIME_W-1:0]   now_q;
	logic [NUM_BTN-1:0]  btn_q;
	logic [MOTION_W-1:0] dx_q;
	logic [MOTION_W-1:0] dy_q;
	logic [MOTION_W-1:0] dz_q;
	logic                still_q;
	logic                chk_q;
	logic                dbl_q;

	// Output register.
	logic                m_valid_q;
	logic [KIND_W-1:0]   kind_q;
	logic [BTN_IDX_W-1:0] which_q;
	logic [MOTION_W-1:0] mx_q;
	logic [MOTION_W-1:0] my_q;
	logic [MOTION_W-1:0] wh_q;
	logic                last_q;

	// Input field views.
	logic [TIME_W-1:0]   in_time;
	logic [NUM_BTN-1:0]  in_btn;
	logic [MOTION_W-1:0] in_dx;
	logic [MOTION_W-1:0] in_dy;
	logic [MOTION_W-1:0] in_dz;

	// Sequencer decode.
	logic                 in_acc;
	logic                 slot_btn;
	logic                 slot_move;
	logic [BTN_IDX_W-1:0] btn_idx;
	logic [NUM_SLOT-1:0]  slot_oh;
	logic [NUM_SLOT-1:0]  pend_next;
	logic                 press;
	logic                 candidate;
	logic                 need_div;
	logic                 dbl;
	logic                 out_free;
	logic                 emit;
	logic                 div_start;
	logic [KIND_W-1:0]    ev_kind;

	// Divider.
	div_stat_t         div_stat;
	logic [TIME_W-1:0] div_quot;
	logic [TIME_W-1:0] interval;
	logic              in_window;

	assign in_time = s_axis_tdata[63:0];
	assign in_btn  = s_axis_tdata[66:64];
	assign in_dx   = s_axis_tdata[74:67];
	assign in_dy   = s_axis_tdata[82:75];
	assign in_dz   = s_axis_tdata[90:83];

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_ms_q <= MAXMS_RESET;
			tpm_q    <= TPM_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_MAX_DBLCLK_MS) begin
				max_ms_q <= cfg_data[MAXMS_W-1:0];
			end else if (cfg_index == REG_TICKS_PER_MS) begin
				tpm_q <= cfg_data[TPM_W-1:0];
			end
		end
	end

	// The lowest pending slot is served first, which gives the required event order.
	always_comb begin
		slot_oh = '0;
		priority if (pend_q[SLOT_MOVE]) begin
			slot_oh[SLOT_MOVE] = 1'b1;
		end else if (pend_q[SLOT_WHEEL]) begin
			slot_oh[SLOT_WHEEL] = 1'b1;
		end else if (pend_q[SLOT_BTN0]) begin
			slot_oh[SLOT_BTN0] = 1'b1;
		end else if (pend_q[SLOT_BTN0 + 1]) begin
			slot_oh[SLOT_BTN0 + 1] = 1'b1;
		end else if (pend_q[SLOT_BTN0 + 2]) begin
			slot_oh[SLOT_BTN0 + 2] = 1'b1;
		end else begin
			slot_oh = '0;
		end
	end

	always_comb begin
		btn_idx = '0;
		for (int i = 0; i < NUM_BTN; i++) begin
			if (slot_oh[SLOT_BTN0 + i]) begin
				btn_idx = BTN_IDX_W'(i);
			end
		end
	end

	assign slot_move = slot_oh[SLOT_MOVE];
	assign slot_btn  = |slot_oh[NUM_SLOT-1:SLOT_BTN0];
	assign pend_next = pend_q & ~slot_oh;
	assign press     = btn_q[btn_idx];
	assign candidate = slot_btn && press && armed_q[btn_idx] && still_q;
	assign need_div  = candidate && !chk_q;
	assign dbl       = candidate && chk_q && dbl_q;
	assign out_free  = !m_valid_q || m_axis_tready;
	assign emit      = (state_q == ST_EMIT) && (pend_q != '0) && !need_div && out_free;
	assign div_start = (state_q == ST_EMIT) && (pend_q != '0) && need_div;

	always_comb begin
		if (slot_move) begin
			ev_kind = EV_MOVE;
		end else if (!slot_btn) begin
			ev_kind = EV_WHEEL;
		end else if (!press) begin
			ev_kind = EV_UP;
		end else if (dbl) begin
			ev_kind = EV_DBL;
		end else begin
			ev_kind = EV_DOWN;
		end
	end

	// Interval since the arming press, wrapping modulo the timestamp range.
	assign interval  = now_q - press_time_q[btn_idx];
	assign in_window = (div_quot[TIME_W-1:MAXMS_W] == '0) &&
		(div_quot[MAXMS_W-1:0] <= max_ms_q);

	mred_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (interval),
		.divisor  (tpm_q),
		.stat     (div_stat),
		.quotient (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			pend_q     <= '0;
			prev_btn_q <= '0;
			armed_q    <= '0;
			chk_q      <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						pend_q[SLOT_MOVE]  <= (in_dx != '0) || (in_dy != '0);
						pend_q[SLOT_WHEEL] <= (in_dz != '0);
						pend_q[NUM_SLOT-1:SLOT_BTN0] <= in_btn ^ prev_btn_q;
						prev_btn_q <= in_btn;
						chk_q      <= 1'b0;
						state_q    <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (pend_q == '0) begin
						state_q <= ST_IDLE;
					end else if (need_div) begin
						state_q <= ST_DIV;
					end else if (emit) begin
						pend_q <= pend_next;
						chk_q  <= 1'b0;
						if (slot_btn && press) begin
							armed_q[btn_idx] <= !dbl;
						end
						if (pend_next == '0) begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_DIV: begin
					if (div_stat.done) begin
						chk_q   <= 1'b1;
						state_q <= ST_EMIT;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			now_q   <= in_time;
			btn_q   <= in_btn;
			dx_q    <= in_dx;
			dy_q    <= in_dy;
			dz_q    <= in_dz;
			still_q <= (in_dx == '0) && (in_dy == '0);
		end
		if (state_q == ST_DIV && div_stat.done) begin
			dbl_q <= in_window;
		end
		// A press that is not a double click re-arms and records its time.
		if (emit && slot_btn && press && !dbl) begin
			press_time_q[btn_idx] <= now_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (emit) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			kind_q  <= ev_kind;
			which_q <= slot_btn ? btn_idx : '0;
			mx_q    <= slot_move ? dx_q : '0;
			my_q    <= slot_move ? dy_q : '0;
			wh_q    <= (!slot_move && !slot_btn) ? dz_q : '0;
			last_q  <= (pend_next == '0);
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {wh_q, my_q, mx_q};
	assign m_axis_tuser  = {which_q, kind_q};
	assign m_axis_tlast  = last_q;

endmodule

// ----- rtl/mred_checker.sv -----
// Port-level checks for the mouse report event decoder, bound to the top level.
// Depends on mred_pkg for the event codes.

module mred_checker
	import mred_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata,
	input logic [4:0]  m_axis_tuser,
	input logic        m_axis_tlast
);

	// A report occupies the sequencer for at least the following cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("report accepted while previous one still in progress");

	// A stalled event is held unchanged.
	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
		&& $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("stalled event changed");

	// Move events carry motion, no button and no wheel.
	a_move_shape: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[2:0] == EV_MOVE |->
		m_axis_tuser[4:3] == 2'd0 && m_axis_tdata[23:16] == 8'd0
		&& m_axis_tdata[15:0] != 16'd0)
		else $error("malformed move event");

	// Wheel events carry a nonzero wheel value only.
	a_wheel_shape: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[2:0] == EV_WHEEL |->
		m_axis_tuser[4:3] == 2'd0 && m_axis_tdata[15:0] == 16'd0
		&& m_axis_tdata[23:16] != 8'd0)
		else $error("malformed wheel event");

	// Button events carry no motion and name a real button.
	a_button_shape: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser[2:0] == EV_DOWN || m_axis_tuser[2:0] == EV_UP
		|| m_axis_tuser[2:0] == EV_DBL) |->
		m_axis_tdata == 24'd0 && m_axis_tuser[4:3] != 2'd3)
		else $error("malformed button event");

endmodule

bind mouse_report_event_decoder mred_checker u_mred_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);

// ----- tb/sv/tb_mouse_report_event_decoder.sv -----
// Self-checking testbench for the mouse report event decoder: random and directed reports,
// config writes between phases, and events checked in order against a built-in decoder.
// Depends on mred_pkg and on the mouse_report_event_decoder RTL only.

module tb_mouse_report_event_decoder;
	import mred_pkg::*;

	localparam int SETTLE_CYCLES = 300;
	localparam int HOLD_CYCLES   = 600;
	localparam int CYCLE_LIMIT   = 1_000_000;

	// Register indexes that the block must ignore.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	localparam logic [NUM_BTN-1:0] LEFT_BIT   = 3'b001;
	localparam logic [NUM_BTN-1:0] RIGHT_BIT  = 3'b010;
	localparam logic [NUM_BTN-1:0] MIDDLE_BIT = 3'b100;
	localparam logic [NUM_BTN-1:0] ALL_BITS   = 3'b111;
	localparam logic [NUM_BTN-1:0] NO_BITS    = 3'b000;

	localparam logic [TIME_W-1:0] TS_TOP = {TIME_W{1'b1}};

	typedef struct packed {
		logic [TIME_W-1:0]          ts;
		logic [NUM_BTN-1:0]         btns;
		logic signed [MOTION_W-1:0] dx;
		logic signed [MOTION_W-1:0] dy;
		logic signed [MOTION_W-1:0] dz;
	} report_t;

	typedef struct packed {
		logic [KIND_W-1:0]          kind;
		logic [BTN_IDX_W-1:0]       btn;
		logic signed [MOTION_W-1:0] mx;
		logic signed [MOTION_W-1:0] my;
		logic signed [MOTION_W-1:0] wh;
		logic                       last;
	} mouse_event_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [95:0]           s_axis_tdata = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [23:0]           m_axis_tdata;
	logic [4:0]            m_axis_tuser;
	logic                  m_axis_tlast;

	mouse_report_event_decoder i_dut (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Decoder state mirrored by the testbench, plus its copy of the registers.
	logic [NUM_BTN-1:0]  held_btns = '0;
	logic [NUM_BTN-1:0]  armed_btns = '0;
	logic [TIME_W-1:0]   press_ts [NUM_BTN] = '{default: '0};
	logic [MAXMS_W-1:0]  dbl_max_ms = MAXMS_RESET;
	logic [TPM_W-1:0]    ticks_ms = TPM_RESET;

	report_t      report_q [$];
	mouse_event_t pending_events [$];
	report_t      cur_report;
	mouse_event_t seen_event;
	mouse_event_t want_event;

	// Stimulus-side view of the last queued report, so that sequences follow on from it.
	logic [TIME_W-1:0]  stim_ts = '0;
	logic [NUM_BTN-1:0] stim_btns = '0;

	int fail_count = 0;
	int cycle_count = 0;
	bit calm = 1'b0;
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;
	int hold_left = 0;

	// Works out the events of one accepted report and queues them in order.
	function automatic void decode_report(report_t r);
		mouse_event_t found [5];
		mouse_event_t e;
		int n;
		int b;
		logic still;
		logic dbl;
		logic [TIME_W-1:0] span;
		logic [TIME_W-1:0] quot;
		n = 0;
		still = (r.dx == 0) && (r.dy == 0);
		if (!still) begin
			e = '0;
			e.kind = EV_MOVE;
			e.mx = r.dx;
			e.my = r.dy;
			found[n] = e;
			n++;
		end
		if (r.dz != 0) begin
			e = '0;
			e.kind = EV_WHEEL;
			e.wh = r.dz;
			found[n] = e;
			n++;
		end
		for (b = 0; b < NUM_BTN; b++) begin
			if (held_btns[b] != r.btns[b]) begin
				e = '0;
				e.btn = BTN_IDX_W'(b);
				if (!r.btns[b]) begin
					e.kind = EV_UP;
				end else begin
					dbl = 1'b0;
					// Only an armed button's press_ts is read, and arming always writes press_ts as well.
					if (armed_btns[b] && still) begin
						span = r.ts - press_ts[b];
						quot = (ticks_ms == 0) ? TS_TOP : span / TIME_W'(ticks_ms);
						dbl = (quot <= TIME_W'(dbl_max_ms));
					end
					if (dbl) begin
						armed_btns[b] = 1'b0;
						e.kind = EV_DBL;
					end else begin
						armed_btns[b] = 1'b1;
						press_ts[b] = r.ts;
						e.kind = EV_DOWN;
					end
				end
				found[n] = e;
				n++;
			end
		end
		held_btns = r.btns;
		if (n > 0) begin
			found[n-1].last = 1'b1;
		end
		for (b = 0; b < n; b++) begin
			pending_events.push_back(found[b]);
		end
	endfunction

	function automatic bit take_break();
		return !calm && ($urandom_range(0, 99) < 25);
	endfunction

	task automatic check_field(string name, logic [7:0] want, logic [7:0] seen);
		if (want !== seen) begin
			fail_count++;
			$display("%0t: event %s expected %0h, got %0h", $time, name, want, seen);
		end
	endtask

	// Report driver: a report stays on the bus until its transaction completes.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				decode_report(cur_report);
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (report_q.size() > 0 && !take_break()) begin
					cur_report = report_q.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {5'b0, cur_report.dz, cur_report.dy, cur_report.dx,
						cur_report.btns, cur_report.ts};
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Event monitor: checks each transaction against the oldest expected event and drives tready,
	// including one long hold-off so that the block backs up and stalls its input.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				seen_event.kind = m_axis_tuser[2:0];
				seen_event.btn = m_axis_tuser[4:3];
				seen_event.mx = m_axis_tdata[7:0];
				seen_event.my = m_axis_tdata[15:8];
				seen_event.wh = m_axis_tdata[23:16];
				seen_event.last = m_axis_tlast;
				if (pending_events.size() == 0) begin
					fail_count++;
					$display("%0t: event expected none, got kind %0d button %0d data %h last %b",
						$time, seen_event.kind, seen_event.btn, m_axis_tdata, m_axis_tlast);
				end else begin
					want_event = pending_events.pop_front();
					check_field("kind", 8'(want_event.kind), 8'(seen_event.kind));
					check_field("button", 8'(want_event.btn), 8'(seen_event.btn));
					check_field("move_x", want_event.mx, seen_event.mx);
					check_field("move_y", want_event.my, seen_event.my);
					check_field("wheel", want_event.wh, seen_event.wh);
					check_field("last", 8'(want_event.last), 8'(seen_event.last));
				end
			end
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= !take_break();
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic push_report(logic [TIME_W-1:0] ts, logic [NUM_BTN-1:0] btns,
		logic signed [MOTION_W-1:0] dx, logic signed [MOTION_W-1:0] dy,
		logic signed [MOTION_W-1:0] dz);
		report_t r;
		r.ts = ts;
		r.btns = btns;
		r.dx = dx;
		r.dy = dy;
		r.dz = dz;
		report_q.push_back(r);
		stim_ts = ts;
		stim_btns = btns;
	endtask

	// Interval in whole milliseconds plus a random remainder below one millisecond; random for a zero rate.
	function automatic logic [TIME_W-1:0] gap_ticks(int unsigned ms);
		logic [TIME_W-1:0] rate;
		rate = TIME_W'(ticks_ms);
		if (rate == 0) begin
			return TIME_W'($urandom);
		end
		return TIME_W'(ms) * rate + ({32'b0, $urandom} % rate);
	endfunction

	// Press intervals cluster on the double-click limit and just past it.
	function automatic int unsigned rand_ms();
		case ($urandom_range(0, 4))
			0: return 0;
			1: return $urandom_range(0, dbl_max_ms);
			2: return dbl_max_ms;
			3: return dbl_max_ms + 1;
			default: return $urandom_range(0, 2 * dbl_max_ms + 2);
		endcase
	endfunction

	function automatic logic signed [MOTION_W-1:0] rand_motion();
		if ($urandom_range(0, 9) < 3) begin
			return '0;
		end
		return MOTION_W'($urandom);
	endfunction

	// Mostly press, release, press, release runs of one button; the rest plain motion and noise.
	task automatic queue_random(int count);
		int made;
		int pick;
		logic [NUM_BTN-1:0] mask;
		logic [TIME_W-1:0] t0;
		logic signed [MOTION_W-1:0] nudge;
		logic signed [MOTION_W-1:0] roll;
		made = 0;
		while (made < count) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				mask = NUM_BTN'(1 << $urandom_range(0, NUM_BTN - 1));
				if ($urandom_range(0, 9) == 0) begin
					stim_ts = TS_TOP - TIME_W'($urandom_range(0, 2000000));
				end
				if (stim_btns & mask) begin
					push_report(stim_ts + 1, stim_btns & ~mask, '0, '0, '0);
					made++;
				end
				t0 = stim_ts + gap_ticks(rand_ms());
				push_report(t0, stim_btns | mask, '0, '0, '0);
				push_report(t0, stim_btns & ~mask, '0, '0, '0);
				nudge = ($urandom_range(0, 4) == 0) ? MOTION_W'($urandom_range(1, 255)) : '0;
				roll = ($urandom_range(0, 4) == 0) ? MOTION_W'($urandom) : '0;
				push_report(t0 + gap_ticks(rand_ms()), stim_btns | mask, nudge, '0, roll);
				push_report(stim_ts + gap_ticks(1), stim_btns & ~mask, '0, '0, '0);
				made += 4;
			end else if (pick < 80) begin
				push_report(stim_ts + gap_ticks($urandom_range(0, 3)),
					stim_btns ^ (($urandom_range(0, 3) == 0) ? NUM_BTN'($urandom_range(1, 7)) : '0),
					rand_motion(), rand_motion(), rand_motion());
				made++;
			end else begin
				push_report({$urandom, $urandom}, NUM_BTN'($urandom_range(0, 7)),
					MOTION_W'($urandom), MOTION_W'($urandom), MOTION_W'($urandom));
				made++;
			end
		end
	endtask

	// Waits until every report has gone in and every event has come out, then gives the block
	// time to return to idle.
	task automatic settle();
		while (report_q.size() != 0 || s_axis_tvalid || pending_events.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_MAX_DBLCLK_MS: dbl_max_ms = value[MAXMS_W-1:0];
			REG_TICKS_PER_MS: ticks_ms = value[TPM_W-1:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	initial begin
		logic [TIME_W-1:0] t_base;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part under the reset settings: 400 ms limit, 1000000 ticks per millisecond.
		t_base = 64'd5_000_000;
		push_report('0, NO_BITS, 0, 0, 0);
		push_report(t_base, NO_BITS, 127, -128, 0);
		push_report(t_base, NO_BITS, -128, 0, 127);
		push_report(t_base, NO_BITS, 0, 0, -128);
		push_report(t_base, NO_BITS, 0, 1, 0);
		push_report(t_base, LEFT_BIT, 0, 0, 0);
		push_report(t_base, NO_BITS, 0, 0, 0);
		// Exactly on the limit: 400 whole milliseconds after flooring.
		push_report(t_base + 64'd400_999_999, LEFT_BIT, 0, 0, 0);
		push_report(t_base + 64'd401_000_000, NO_BITS, 0, 0, 0);
		// The double click disarmed the button, so this is a plain press again.
		t_base = t_base + 64'd1_000_000_000;
		push_report(t_base, LEFT_BIT, 0, 0, 0);
		push_report(t_base, NO_BITS, 0, 0, 0);
		// One millisecond past the limit re-arms instead.
		t_base = t_base + 64'd401_000_000;
		push_report(t_base, LEFT_BIT, 0, 0, 0);
		push_report(t_base, NO_BITS, 0, 0, 0);
		// Motion in the second press blocks the double click.
		push_report(t_base + 1, RIGHT_BIT, 0, 0, 0);
		push_report(t_base + 2, NO_BITS, 0, 0, 0);
		push_report(t_base + 3, RIGHT_BIT, 1, 0, 0);
		push_report(t_base + 4, NO_BITS, 0, 0, 0);
		// Five events from one report, each way round.
		push_report(t_base + 5, ALL_BITS, -1, 1, -1);
		push_report(t_base + 6, NO_BITS, 1, -1, 1);
		// A press interval that wraps through zero.
		push_report(TS_TOP - 64'd500_000, MIDDLE_BIT, 0, 0, 0);
		push_report(TS_TOP, NO_BITS, 0, 0, 0);
		push_report(64'd300_000, MIDDLE_BIT, 0, 0, 0);
		push_report(64'd300_001, NO_BITS, 0, 0, 0);
		push_report(64'd300_002, LEFT_BIT | MIDDLE_BIT, 0, 0, 0);
		push_report(64'd300_003, NO_BITS, 0, 0, 0);
		settle();

		queue_random(100);
		settle();

		// Tightest limit and finest ticks; no idling here, but one long output hold-off.
		write_reg(REG_MAX_DBLCLK_MS, CFG_DATA_W'(0));
		write_reg(REG_TICKS_PER_MS, CFG_DATA_W'(1));
		calm = 1'b1;
		hold_req = 1'b1;
		queue_random(60);
		settle();
		calm = 1'b0;

		write_reg(REG_MAX_DBLCLK_MS, CFG_DATA_W'(16'hFFFF));
		write_reg(REG_TICKS_PER_MS, 32'hFFFF_FFFF);
		queue_random(60);
		settle();

		// A zero tick rate rules out any double click; writes to unused indexes change nothing.
		write_reg(REG_TICKS_PER_MS, '0);
		write_reg(REG_MAX_DBLCLK_MS, CFG_DATA_W'($urandom_range(0, 65535)));
		write_reg(REG_SPARE_A, $urandom);
		write_reg(REG_SPARE_B, $urandom);
		queue_random(50);
		settle();

		write_reg(REG_MAX_DBLCLK_MS, CFG_DATA_W'($urandom_range(0, 2000)));
		write_reg(REG_TICKS_PER_MS, CFG_DATA_W'($urandom_range(1, 100000)));
		queue_random(80);
		settle();

		write_reg(REG_MAX_DBLCLK_MS, $urandom);
		write_reg(REG_TICKS_PER_MS, $urandom);
		queue_random(60);
		settle();

		if (fail_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/mred_pkg.sv
rtl/mred_div.sv
rtl/mouse_report_event_decoder.sv
rtl/mred_checker.sv
tb/sv/tb_mouse_report_event_decoder.sv
